// ===== rtl/bppd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppd_pkg
// Shared types and constants of the two-beam passage direction detector.
// ----------------------------------------------------------------------------
package bppd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int LEVEL_BITS  = 12;
    localparam int MS_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [LEVEL_BITS-1:0] BLOCK_LEVEL_RST = LEVEL_BITS'(900);
    localparam logic [LEVEL_BITS-1:0] CLEAR_LEVEL_RST = LEVEL_BITS'(1200);
    localparam logic [MS_BITS-1:0]    DEBOUNCE_RST    = MS_BITS'(50);
    localparam logic [MS_BITS-1:0]    TIMEOUT_RST     = MS_BITS'(5000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BEAM1_BLOCK = 3'd0,
        CFG_BEAM1_CLEAR = 3'd1,
        CFG_BEAM2_BLOCK = 3'd2,
        CFG_BEAM2_CLEAR = 3'd3,
        CFG_DEBOUNCE    = 3'd4,
        CFG_TIMEOUT     = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_BOTH      = 3'd1,
        EV_ENTRY_REQ = 3'd2,
        EV_EXIT_REQ  = 3'd3,
        EV_ENTRY_OK  = 3'd4,
        EV_TAILGATE  = 3'd5,
        EV_DONE      = 3'd6,
        EV_CANCEL    = 3'd7
    } event_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ENT_W1C = 4'd1,
        PH_ENT_W2B = 4'd2,
        PH_ENT_W2C = 4'd3,
        PH_EXT_W2C = 4'd4,
        PH_EXT_W1B = 4'd5,
        PH_EXT_W1C = 4'd6,
        PH_SIMUL   = 4'd7,
        PH_TAIL    = 4'd8
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] beam1_sample;
        logic [SAMPLE_BITS-1:0] beam2_sample;
        logic                   samples_ok;
        logic [TIME_BITS-1:0]   now_ms;
    } in_item_t;

    typedef struct packed {
        event_t event_code;
        logic   path_clear;
        logic   beam1_blocked;
        logic   beam2_blocked;
    } out_item_t;

    // per-beam status handed from a lane to the sequencer
    typedef struct packed {
        logic stable;
        logic next;
    } lane_status_t;

endpackage

// ===== rtl/bppd_beam_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppd_beam_lane
// One beam: hysteresis against the stable state, then time debounce with a
// candidate state and the time it was first seen.
// ----------------------------------------------------------------------------
module bppd_beam_lane
    import bppd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_BITS-1:0]   now_ms,
    input  logic [LEVEL_BITS-1:0]  block_level,
    input  logic [LEVEL_BITS-1:0]  clear_level,
    input  logic [MS_BITS-1:0]     debounce_ms,
    output lane_status_t           status
);

    logic                 stable_reg, stable_next;
    logic                 cand_reg, cand_next;
    logic [TIME_BITS-1:0] since_reg, since_next;
    logic                 measured;
    logic [TIME_BITS-1:0] elapsed;

    always_comb begin
        if (stable_reg) begin
            measured = !(SAMPLE_BITS'(sample) >= SAMPLE_BITS'(clear_level));
        end else begin
            measured = SAMPLE_BITS'(sample) <= SAMPLE_BITS'(block_level);
        end
        elapsed     = now_ms - since_reg;
        cand_next   = cand_reg;
        since_next  = since_reg;
        stable_next = stable_reg;
        if (measured == stable_reg) begin
            cand_next  = stable_reg;
            since_next = now_ms;
        end else if (measured != cand_reg) begin
            cand_next  = measured;
            since_next = now_ms;
        end else if (elapsed >= TIME_BITS'(debounce_ms)) begin
            stable_next = measured;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= 1'b0;
            cand_reg   <= 1'b0;
            since_reg  <= '0;
        end else if (en) begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
            since_reg  <= since_next;
        end
    end

    assign status.stable = stable_reg;
    assign status.next   = stable_next;

endmodule

// ===== rtl/bppd_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppd_sequencer
// Merges both lanes: stable edges drive the passage phase machine, with a
// timeout on incomplete sequences.
// ----------------------------------------------------------------------------
module bppd_sequencer
    import bppd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [TIME_BITS-1:0] now_ms,
    input  logic [MS_BITS-1:0]   timeout_ms,
    input  lane_status_t         lane1,
    input  lane_status_t         lane2,
    output event_t               event_code
);

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 b1, b2, blk1, clr1, blk2, both_clear;
    logic                 start_set, timed_out, waiting;
    logic [TIME_BITS-1:0] elapsed;
    event_t               ev;

    assign b1         = lane1.next;
    assign b2         = lane2.next;
    assign blk1       = !lane1.stable && b1;
    assign clr1       = lane1.stable && !b1;
    assign blk2       = !lane2.stable && b2;
    assign both_clear = !b1 && !b2;
    assign elapsed    = now_ms - start_reg;

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        start_set  = 1'b0;
        ev         = EV_NONE;
        unique case (phase_reg)
            PH_IDLE: begin
                if (blk1 && blk2) begin
                    phase_next = PH_SIMUL;
                    ev         = EV_BOTH;
                end else if (blk1) begin
                    phase_next = PH_ENT_W1C;
                    start_set  = 1'b1;
                    ev         = EV_ENTRY_REQ;
                end else if (blk2) begin
                    phase_next = PH_EXT_W2C;
                    start_set  = 1'b1;
                    ev         = EV_EXIT_REQ;
                end
            end
            PH_ENT_W1C: begin
                if (blk2 && b1) begin
                    phase_next = PH_SIMUL;
                    ev         = EV_BOTH;
                end else if (blk2) begin
                    phase_next = PH_ENT_W2C;
                    ev         = EV_ENTRY_OK;
                end else if (clr1) begin
                    phase_next = PH_ENT_W2B;
                end
            end
            PH_ENT_W2B: begin
                if (blk2 && b1) begin
                    phase_next = PH_TAIL;
                    ev         = EV_TAILGATE;
                end else if (blk2) begin
                    phase_next = PH_ENT_W2C;
                    ev         = EV_ENTRY_OK;
                end
            end
            PH_ENT_W2C: begin
                if (blk1) begin
                    phase_next = PH_TAIL;
                    ev         = EV_TAILGATE;
                end else if (both_clear) begin
                    phase_next = PH_IDLE;
                    start_next = '0;
                    ev         = EV_DONE;
                end
            end
            PH_EXT_W2C: begin
                if (blk1 && b2) begin
                    phase_next = PH_SIMUL;
                    ev         = EV_BOTH;
                end else if (blk1) begin
                    phase_next = PH_EXT_W1C;
                end else if (lane2.stable && !b2) begin
                    phase_next = PH_EXT_W1B;
                end
            end
            PH_EXT_W1B: begin
                if (blk1) begin
                    phase_next = PH_EXT_W1C;
                end
            end
            PH_EXT_W1C: begin
                if (both_clear) begin
                    phase_next = PH_IDLE;
                    start_next = '0;
                    ev         = EV_DONE;
                end
            end
            PH_SIMUL: begin
                if (both_clear) begin
                    phase_next = PH_IDLE;
                    start_next = '0;
                    ev         = EV_CANCEL;
                end
            end
            PH_TAIL: begin
                if (both_clear) begin
                    phase_next = PH_IDLE;
                    start_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                start_next = '0;
            end
        endcase

        if (start_set) begin
            start_next = now_ms;
            timed_out  = (timeout_ms == '0);
        end else begin
            timed_out  = elapsed >= TIME_BITS'(timeout_ms);
        end

        waiting = (phase_next == PH_ENT_W1C) || (phase_next == PH_ENT_W2B) ||
                  (phase_next == PH_EXT_W2C) || (phase_next == PH_EXT_W1B);
        if (waiting && timed_out) begin
            phase_next = PH_IDLE;
            start_next = '0;
            ev         = EV_CANCEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            start_reg <= '0;
        end else if (en) begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

    assign event_code = en ? ev : EV_NONE;

    a_req_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && (ev == EV_ENTRY_REQ || ev == EV_EXIT_REQ)) |-> (phase_reg == PH_IDLE))
        else $error("request event outside idle phase");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && (ev == EV_DONE || ev == EV_CANCEL)) |=> (phase_reg == PH_IDLE))
        else $error("sequence not closed after done or cancel");

endmodule

// ===== rtl/beam_pair_passage_direction_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_pair_passage_direction_detector_unit
// Two-beam passage direction detector: per-beam lanes plus phase sequencer.
// ----------------------------------------------------------------------------
// Takes one poll per clock cycle while m_ready is high and returns one result
// beat per poll, in the cycle after the poll is accepted. Both beam lanes and
// the sequencer update in the same cycle, so the rate is set by the path of a
// 12-bit threshold compare, a 32-bit elapsed-time compare and the phase
// decode. The result register frees on the cycle it is taken, so polls stream
// without gaps while the consumer keeps m_ready high. Configuration writes are
// taken in every cycle; write them only while no poll is in flight.
// ----------------------------------------------------------------------------
module beam_pair_passage_direction_detector_unit
    import bppd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [LEVEL_BITS-1:0] b1_block_reg, b1_clear_reg, b2_block_reg, b2_clear_reg;
    logic [MS_BITS-1:0]    debounce_reg, timeout_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg, out_data_next;
    logic                  accept, step;
    lane_status_t          lane1, lane2;
    event_t                ev;
    logic                  b1, b2;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign step      = accept && s_data.samples_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_block_reg <= BLOCK_LEVEL_RST;
            b1_clear_reg <= CLEAR_LEVEL_RST;
            b2_block_reg <= BLOCK_LEVEL_RST;
            b2_clear_reg <= CLEAR_LEVEL_RST;
            debounce_reg <= DEBOUNCE_RST;
            timeout_reg  <= TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BEAM1_BLOCK: b1_block_reg <= cfg_data[LEVEL_BITS-1:0];
                CFG_BEAM1_CLEAR: b1_clear_reg <= cfg_data[LEVEL_BITS-1:0];
                CFG_BEAM2_BLOCK: b2_block_reg <= cfg_data[LEVEL_BITS-1:0];
                CFG_BEAM2_CLEAR: b2_clear_reg <= cfg_data[LEVEL_BITS-1:0];
                CFG_DEBOUNCE:    debounce_reg <= cfg_data[MS_BITS-1:0];
                CFG_TIMEOUT:     timeout_reg  <= cfg_data[MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    bppd_beam_lane u_lane1 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (step),
        .sample      (s_data.beam1_sample),
        .now_ms      (s_data.now_ms),
        .block_level (b1_block_reg),
        .clear_level (b1_clear_reg),
        .debounce_ms (debounce_reg),
        .status      (lane1)
    );

    bppd_beam_lane u_lane2 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (step),
        .sample      (s_data.beam2_sample),
        .now_ms      (s_data.now_ms),
        .block_level (b2_block_reg),
        .clear_level (b2_clear_reg),
        .debounce_ms (debounce_reg),
        .status      (lane2)
    );

    bppd_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (step),
        .now_ms     (s_data.now_ms),
        .timeout_ms (timeout_reg),
        .lane1      (lane1),
        .lane2      (lane2),
        .event_code (ev)
    );

    assign b1 = s_data.samples_ok ? lane1.next : lane1.stable;
    assign b2 = s_data.samples_ok ? lane2.next : lane2.stable;

    always_comb begin
        out_data_next.event_code    = ev;
        out_data_next.path_clear    = !b1 && !b2;
        out_data_next.beam1_blocked = b1;
        out_data_next.beam2_blocked = b2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_failed_poll_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.samples_ok) |=> (m_data.event_code == EV_NONE))
        else $error("failed poll reported an event");

    a_beat_follows_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted poll produced no result beat");

    a_state_held_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.samples_ok) |=>
            (lane1.stable == $past(lane1.stable)) && (lane2.stable == $past(lane2.stable)))
        else $error("beam state changed on failed poll");

endmodule

// ===== tb/bppd_passage_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bppd_passage_checker
// Watches the poll, result and register channels of the passage direction
// detector. It keeps its own copy of the beam debounce and phase sequencer,
// predicts one report per accepted poll and compares each result beat, field
// by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module bppd_passage_checker
    import bppd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_item_t                 s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_item_t                m_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       mismatches,
    output int                       outstanding
);

    typedef struct packed {
        logic                 verdict;
        logic                 cand;
        logic [TIME_BITS-1:0] since;
    } settle_t;

    logic [LEVEL_BITS-1:0] block_lvl1, clear_lvl1, block_lvl2, clear_lvl2;
    logic [MS_BITS-1:0]    debounce_win, timeout_win;
    logic                  stable1, stable2, cand1, cand2;
    logic [TIME_BITS-1:0]  since1, since2, seq_begin;
    phase_t                phase;
    out_item_t             pending_reports[$];

    function automatic logic beam_reading(input logic [SAMPLE_BITS-1:0] sample,
                                          input logic stable,
                                          input logic [LEVEL_BITS-1:0] blk,
                                          input logic [LEVEL_BITS-1:0] clr);
        return stable ? (sample < clr) : (sample <= blk);
    endfunction

    function automatic settle_t settle_beam(input logic seen, input logic stable,
                                            input logic cand,
                                            input logic [TIME_BITS-1:0] since,
                                            input logic [TIME_BITS-1:0] stamp);
        settle_t res;
        logic [TIME_BITS-1:0] age;
        age = stamp - since;
        res.verdict = stable;
        res.cand = cand;
        res.since = since;
        if (seen == stable || seen != cand) begin
            res.cand = seen;
            res.since = stamp;
        end else if (age >= TIME_BITS'(debounce_win)) begin
            res.verdict = seen;
        end
        return res;
    endfunction

    function automatic out_item_t predict_report(input in_item_t poll);
        event_t ev;
        logic m1, m2, b1, b2, rise1, fall1, rise2, fall2, both_clear;
        settle_t s1, s2;
        logic [TIME_BITS-1:0] elapsed;
        out_item_t rep;
        ev = EV_NONE;
        if (poll.samples_ok) begin
            m1 = beam_reading(poll.beam1_sample, stable1, block_lvl1, clear_lvl1);
            m2 = beam_reading(poll.beam2_sample, stable2, block_lvl2, clear_lvl2);
            s1 = settle_beam(m1, stable1, cand1, since1, poll.now_ms);
            s2 = settle_beam(m2, stable2, cand2, since2, poll.now_ms);
            cand1 = s1.cand;
            since1 = s1.since;
            cand2 = s2.cand;
            since2 = s2.since;
            b1 = s1.verdict;
            b2 = s2.verdict;
            rise1 = !stable1 && b1;
            fall1 = stable1 && !b1;
            rise2 = !stable2 && b2;
            fall2 = stable2 && !b2;
            both_clear = !b1 && !b2;
            case (phase)
                PH_IDLE: begin
                    if (rise1 && rise2) begin
                        phase = PH_SIMUL;
                        ev = EV_BOTH;
                    end else if (rise1) begin
                        phase = PH_ENT_W1C;
                        seq_begin = poll.now_ms;
                        ev = EV_ENTRY_REQ;
                    end else if (rise2) begin
                        phase = PH_EXT_W2C;
                        seq_begin = poll.now_ms;
                        ev = EV_EXIT_REQ;
                    end
                end
                PH_ENT_W1C: begin
                    if (rise2 && b1) begin
                        phase = PH_SIMUL;
                        ev = EV_BOTH;
                    end else if (rise2) begin
                        phase = PH_ENT_W2C;
                        ev = EV_ENTRY_OK;
                    end else if (fall1) begin
                        phase = PH_ENT_W2B;
                    end
                end
                PH_ENT_W2B: begin
                    if (rise2 && b1) begin
                        phase = PH_TAIL;
                        ev = EV_TAILGATE;
                    end else if (rise2) begin
                        phase = PH_ENT_W2C;
                        ev = EV_ENTRY_OK;
                    end
                end
                PH_ENT_W2C: begin
                    if (rise1) begin
                        phase = PH_TAIL;
                        ev = EV_TAILGATE;
                    end else if (both_clear) begin
                        phase = PH_IDLE;
                        seq_begin = '0;
                        ev = EV_DONE;
                    end
                end
                PH_EXT_W2C: begin
                    if (rise1 && b2) begin
                        phase = PH_SIMUL;
                        ev = EV_BOTH;
                    end else if (rise1) begin
                        phase = PH_EXT_W1C;
                    end else if (fall2) begin
                        phase = PH_EXT_W1B;
                    end
                end
                PH_EXT_W1B: begin
                    if (rise1) phase = PH_EXT_W1C;
                end
                PH_EXT_W1C: begin
                    if (both_clear) begin
                        phase = PH_IDLE;
                        seq_begin = '0;
                        ev = EV_DONE;
                    end
                end
                PH_SIMUL: begin
                    if (both_clear) begin
                        phase = PH_IDLE;
                        seq_begin = '0;
                        ev = EV_CANCEL;
                    end
                end
                PH_TAIL: begin
                    if (both_clear) begin
                        phase = PH_IDLE;
                        seq_begin = '0;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    seq_begin = '0;
                end
            endcase
            // half-finished sequences expire, judged on the phase after this poll
            elapsed = poll.now_ms - seq_begin;
            if ((phase == PH_ENT_W1C || phase == PH_ENT_W2B ||
                 phase == PH_EXT_W2C || phase == PH_EXT_W1B) &&
                elapsed >= TIME_BITS'(timeout_win)) begin
                phase = PH_IDLE;
                seq_begin = '0;
                ev = EV_CANCEL;
            end
            stable1 = b1;
            stable2 = b2;
        end
        rep.event_code = ev;
        rep.path_clear = !stable1 && !stable2;
        rep.beam1_blocked = stable1;
        rep.beam2_blocked = stable2;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            block_lvl1 = BLOCK_LEVEL_RST;
            clear_lvl1 = CLEAR_LEVEL_RST;
            block_lvl2 = BLOCK_LEVEL_RST;
            clear_lvl2 = CLEAR_LEVEL_RST;
            debounce_win = DEBOUNCE_RST;
            timeout_win = TIMEOUT_RST;
            stable1 = 1'b0;
            stable2 = 1'b0;
            cand1 = 1'b0;
            cand2 = 1'b0;
            since1 = '0;
            since2 = '0;
            phase = PH_IDLE;
            seq_begin = '0;
            pending_reports.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("result beat with no poll waiting");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("event_code", want.event_code, m_data.event_code);
                    check_field("path_clear", 3'(want.path_clear), 3'(m_data.path_clear));
                    check_field("beam1_blocked", 3'(want.beam1_blocked),
                                3'(m_data.beam1_blocked));
                    check_field("beam2_blocked", 3'(want.beam2_blocked),
                                3'(m_data.beam2_blocked));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BEAM1_BLOCK: block_lvl1 = cfg_data[LEVEL_BITS-1:0];
                    CFG_BEAM1_CLEAR: clear_lvl1 = cfg_data[LEVEL_BITS-1:0];
                    CFG_BEAM2_BLOCK: block_lvl2 = cfg_data[LEVEL_BITS-1:0];
                    CFG_BEAM2_CLEAR: clear_lvl2 = cfg_data[LEVEL_BITS-1:0];
                    CFG_DEBOUNCE:    debounce_win = cfg_data;
                    CFG_TIMEOUT:     timeout_win = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) pending_reports.push_back(predict_report(s_data));
        end
        outstanding = pending_reports.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the passage direction detector. A short directed
// run walks the sequencer through its events, threshold edges, a timeout and
// a timestamp wrap; then random walker passages with glitches and failed
// reads run under six register settings and three idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import bppd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_POLLS = 305;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    in_item_t                 s_data;
    logic                     m_valid;
    logic                     m_ready;
    out_item_t                m_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int polls_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic [TIME_BITS-1:0]  now_track;
    logic [LEVEL_BITS-1:0] b1_blk, b1_clr, b2_blk, b2_clr;
    logic [MS_BITS-1:0]    debounce_set, timeout_set;

    always #4 aclk = ~aclk;

    beam_pair_passage_direction_detector_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bppd_passage_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_poll(input logic [SAMPLE_BITS-1:0] s1,
                             input logic [SAMPLE_BITS-1:0] s2,
                             input logic ok, input logic [TIME_BITS-1:0] stamp);
        in_item_t poll;
        poll.beam1_sample = s1;
        poll.beam2_sample = s2;
        poll.samples_ok = ok;
        poll.now_ms = stamp;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= poll;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        polls_sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic apply_setting(input int k);
        case (k)
            0: begin
                b1_blk = 12'd900;  b1_clr = 12'd1200; b2_blk = 12'd900;  b2_clr = 12'd1200;
                debounce_set = 16'd50;    timeout_set = 16'd5000;
            end
            1: begin
                b1_blk = 12'd0;    b1_clr = 12'd4095; b2_blk = 12'd0;    b2_clr = 12'd4095;
                debounce_set = 16'd0;     timeout_set = 16'hFFFF;
            end
            2: begin
                b1_blk = 12'd4095; b1_clr = 12'd0;    b2_blk = 12'd4095; b2_clr = 12'd0;
                debounce_set = 16'hFFFF; timeout_set = 16'd0;
            end
            3: begin
                b1_blk = 12'd2000; b1_clr = 12'd2100; b2_blk = 12'd1500; b2_clr = 12'd3000;
                debounce_set = 16'd20;    timeout_set = 16'd300;
            end
            4: begin
                // inverted hysteresis
                b1_blk = 12'd3000; b1_clr = 12'd1000; b2_blk = 12'd2500; b2_clr = 12'd500;
                debounce_set = 16'd5;     timeout_set = 16'd1000;
            end
            default: begin
                b1_blk = 12'($urandom_range(200, 2000));
                b1_clr = b1_blk + 12'($urandom_range(0, 1500));
                b2_blk = 12'($urandom_range(200, 2000));
                b2_clr = b2_blk + 12'($urandom_range(0, 1500));
                debounce_set = 16'($urandom_range(0, 200));
                timeout_set = 16'($urandom_range(100, 4000));
            end
        endcase
        write_reg(CFG_BEAM1_BLOCK, 16'(b1_blk));
        write_reg(CFG_BEAM1_CLEAR, 16'(b1_clr));
        write_reg(CFG_BEAM2_BLOCK, 16'(b2_blk));
        write_reg(CFG_BEAM2_CLEAR, 16'(b2_clr));
        write_reg(CFG_DEBOUNCE, debounce_set);
        write_reg(CFG_TIMEOUT, timeout_set);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] beam_sample(input bit dark,
                                                           input logic [LEVEL_BITS-1:0] blk,
                                                           input logic [LEVEL_BITS-1:0] clr);
        if ($urandom_range(0, 19) == 0) return SAMPLE_BITS'($urandom_range(0, 4095));
        return dark ? SAMPLE_BITS'($urandom_range(0, blk))
                    : SAMPLE_BITS'($urandom_range(clr, 4095));
    endfunction

    // hold one beam pattern for a few polls, time stepping against the debounce
    task automatic hold_beams(input bit dark1, input bit dark2, input int polls);
        int step_cap;
        logic [TIME_BITS-1:0] step;
        step_cap = int'(debounce_set) / 2 + 2;
        repeat (polls) begin
            if ($urandom_range(0, 39) == 0)
                step = $urandom_range(0, 2 * int'(timeout_set) + 1);
            else
                step = $urandom_range(1, step_cap);
            now_track += step;
            if ($urandom_range(0, 29) == 0)
                push_poll(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()), 1'b0, $urandom());
            else
                push_poll(beam_sample(dark1, b1_blk, b1_clr),
                          beam_sample(dark2, b2_blk, b2_clr), 1'b1, now_track);
        end
    endtask

    // bit 1 = beam one dark, bit 0 = beam two dark
    task automatic run_passage();
        bit [1:0] steps[$];
        int kind;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1, 2: steps = '{2'b10, 2'b11, 2'b01, 2'b00};
            3, 4, 5: steps = '{2'b01, 2'b11, 2'b10, 2'b00};
            6:       steps = '{2'b11, 2'b00};
            7:       steps = '{2'b10, 2'b00, 2'b11, 2'b00};
            8:       steps = '{2'b10, 2'b11, 2'b01, 2'b11, 2'b00};
            9:       steps = '{2'b10, 2'b00, 2'b01, 2'b00};
            10:      steps = '{2'b01, 2'b00, 2'b10, 2'b00};
            default: repeat (3) steps.push_back(2'($urandom()));
        endcase
        foreach (steps[i]) hold_beams(steps[i][1], steps[i][0], $urandom_range(2, 9));
        if ($urandom_range(0, 24) == 0) drain_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed walk on reset registers: 900/1200 levels, 50 ms, 5000 ms
        send_idle_pct = 20;
        recv_idle_pct = 84;
        push_poll(12'd4095, 12'd4095, 1'b1, 32'd0);
        push_poll(12'd0,    12'd0,    1'b0, 32'hFFFF_FFFF);
        push_poll(12'd900,  12'd1200, 1'b1, 32'd10);
        push_poll(12'd0,    12'd1199, 1'b1, 32'd60);
        push_poll(12'd0,    12'd0,    1'b1, 32'd70);
        push_poll(12'd0,    12'd0,    1'b1, 32'd120);
        push_poll(12'd1199, 12'd4095, 1'b1, 32'd130);
        push_poll(12'd1200, 12'd4095, 1'b1, 32'd140);
        push_poll(12'd4095, 12'd4095, 1'b1, 32'd190);
        push_poll(12'd0,    12'd4095, 1'b1, 32'd200);
        push_poll(12'd0,    12'd4095, 1'b1, 32'd250);
        push_poll(12'd4095, 12'd4095, 1'b1, 32'd260);
        push_poll(12'd4095, 12'd4095, 1'b1, 32'd310);
        push_poll(12'd4095, 12'd0,    1'b1, 32'd320);
        push_poll(12'd4095, 12'd0,    1'b1, 32'd370);
        push_poll(12'd0,    12'd0,    1'b1, 32'd380);
        push_poll(12'd0,    12'd0,    1'b1, 32'd430);
        push_poll(12'd4095, 12'd4095, 1'b1, 32'd440);
        push_poll(12'd4095, 12'd4095, 1'b1, 32'd490);
        push_poll(12'd4095, 12'd0,    1'b1, 32'd500);
        push_poll(12'd4095, 12'd0,    1'b1, 32'd550);
        // exit sequence expires across a long gap, then entry across the wrap
        push_poll(12'd0,    12'd0,    1'b1, 32'hFFFF_FFF0);
        push_poll(12'd0,    12'd0,    1'b1, 32'h0000_0022);
        push_poll(12'd4095, 12'd4095, 1'b1, 32'h0000_0030);

        now_track = 32'hFFFF_F000;
        for (int seg = 0; seg < 6; seg++) begin
            drain_results();
            repeat (3) @(negedge aclk);
            apply_setting(seg);
            case (seg / 2)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            polls_sent = 0;
            while (polls_sent < SEGMENT_POLLS) run_passage();
        end

        drain_results();
        repeat (4) @(negedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
